FILE: design/dpbp_pkg.sv
package dpbp_pkg;

  // code word widths
  localparam int CODE_W = 72;
  localparam int LEN_W  = 7;
  localparam int BUF_W  = CODE_W + 8;

  localparam logic [11:0] RADIX_LIMIT = 12'd4080;
  localparam logic [7:0]  ESC_BYTE    = 8'hff;
  localparam logic [6:0]  NORMAL_LEN  = 7'd51;
  localparam logic [6:0]  ESC_LEN     = 7'd72;

  // first radix of each offset width (index is the width)
  localparam logic [11:0] RBASE [10] = '{
    12'd0, 12'd0, 12'd8, 12'd512, 12'd1008, 12'd1520,
    12'd2032, 12'd2544, 12'd3056, 12'd3568
  };

  // first group number of each offset width
  localparam logic [7:0] GBASE [10] = '{
    8'd0, 8'd0, 8'd4, 8'd130, 8'd192, 8'd224, 8'd240, 8'd248, 8'd252, 8'd254
  };

  typedef struct packed {
    logic [3:0] w;
    logic [7:0] group;
    logic [8:0] off;
  } lookup_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;  // left aligned
    logic [LEN_W-1:0]  len;
    logic              eos;
    logic              err;
  } code_t;

  // prefix table for radix below the limit
  function automatic lookup_t prefix_lookup(input logic [11:0] radix);
    lookup_t     res;
    logic [3:0]  w;
    logic [11:0] rel;
    w = 4'd1;
    for (int i = 2; i <= 9; i++) begin
      if (radix >= RBASE[i]) w = 4'(i);
    end
    rel = radix - RBASE[w];
    res.w = w;
    res.group = GBASE[w] + 8'(rel >> w);
    res.off = 9'(rel & ((12'd1 << w) - 12'd1));
    return res;
  endfunction

endpackage

FILE: design/dpbp_encode.sv
module dpbp_encode
  import dpbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] endpoint,
  input  logic [33:0] chain_index,
  input  logic        end_of_stream,
  output logic        code_valid,
  output code_t       code,
  input  logic        code_take
);

  logic        a_vld;
  logic [63:0] a_ep;
  logic [33:0] a_idx;
  logic        a_eos;
  logic [63:0] last_endpoint;
  logic        a_ready, a_adv, b_ready;

  logic [63:0]       diff;
  logic [51:0]       delta;
  logic              esc;
  lookup_t           lk;
  logic [8:0]        off_al;
  logic [CODE_W-1:0] head, tail;
  code_t             code_next;

  assign b_ready  = !code_valid || code_take;
  assign a_adv    = a_vld && b_ready;
  assign a_ready  = !a_vld || a_adv;
  assign in_stall = !a_ready;

  always_comb begin
    diff = a_ep - last_endpoint;
    delta = diff[63:12];
    esc = (|delta[51:22]) || (delta[21:10] >= RADIX_LIMIT) || a_idx[33];
    lk = prefix_lookup(delta[21:10]);
    off_al = 9'(lk.off << (4'd9 - lk.w));
    head = {lk.group, off_al, 55'd0};
    tail = {delta[9:0], a_idx[32:0], 29'd0} >> (5'd8 + {1'b0, lk.w});
    code_next.eos = a_eos;
    code_next.err = esc && (|delta[51:30]);
    if (esc) begin
      code_next.bits = {ESC_BYTE, delta[29:0], a_idx};
      code_next.len = ESC_LEN;
    end else begin
      code_next.bits = head | tail;
      code_next.len = NORMAL_LEN + {3'd0, lk.w};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      code_valid <= 1'b0;
      last_endpoint <= 64'd0;
    end else begin
      if (a_ready) a_vld <= in_valid;
      if (b_ready) code_valid <= a_vld;
      if (a_adv) last_endpoint <= a_ep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_ep <= endpoint;
      a_idx <= chain_index;
      a_eos <= end_of_stream;
    end
    if (a_adv) code <= code_next;
  end

endmodule

FILE: design/dpbp_serial.sv
module dpbp_serial
  import dpbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       code_valid,
  input  code_t      code,
  output logic       code_take,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       range_error
);

  logic [BUF_W-1:0] pack_buf;
  logic [3:0]       buf_cnt;
  logic             buf_err;
  logic [6:0]       pend_bits;
  logic [2:0]       pend_cnt;

  logic             move, load;
  logic [7:0]       pend_top;
  logic [BUF_W-1:0] merged, merged_sh;
  logic [6:0]       total;
  logic [3:0]       full_bytes;
  logic [2:0]       rem;
  logic [7:0]       tail_byte;
  logic [3:0]       emit_cnt;
  logic [6:0]       pend_bits_next;
  logic [2:0]       pend_cnt_next;

  assign move      = (buf_cnt != 4'd0) && (!out_valid || !out_stall);
  assign code_take = (buf_cnt == 4'd0) || (buf_cnt == 4'd1 && move);
  assign load      = code_valid && code_take;

  always_comb begin
    pend_top = 8'({1'b0, pend_bits} << (4'd8 - {1'b0, pend_cnt}));
    merged = {pend_top, {CODE_W{1'b0}}} | ({code.bits, 8'd0} >> pend_cnt);
    total = code.len + {4'd0, pend_cnt};
    full_bytes = total[6:3];
    rem = total[2:0];
    merged_sh = merged << {full_bytes, 3'b000};
    tail_byte = merged_sh[BUF_W-1 -: 8];
    if (code.eos) begin
      emit_cnt = full_bytes + {3'd0, rem != 3'd0};
      pend_bits_next = 7'd0;
      pend_cnt_next = 3'd0;
    end else begin
      emit_cnt = full_bytes;
      pend_bits_next = 7'(tail_byte >> (4'd8 - {1'b0, rem}));
      pend_cnt_next = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 4'd0;
      pend_bits <= 7'd0;
      pend_cnt <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        buf_cnt <= emit_cnt;
        pend_bits <= pend_bits_next;
        pend_cnt <= pend_cnt_next;
      end else if (move) begin
        buf_cnt <= buf_cnt - 4'd1;
      end
      if (move) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pack_buf <= merged;
      buf_err <= code.err;
    end else if (move) begin
      pack_buf <= pack_buf << 8;
    end
    if (move) begin
      out_byte <= pack_buf[BUF_W-1 -: 8];
      last_of_run <= (buf_cnt == 4'd1);
      range_error <= buf_err;
    end
  end

endmodule

FILE: design/delta_prefix_bit_packer_core.sv
// delta prefix bit packer
// input channel: in_valid / in_stall, one beat per endpoint with its chain
//   index and an end_of_stream mark; a beat is taken when valid is high and
//   stall is low
// output channel: out_valid / out_stall, one packed byte per beat, first bit
//   in the msb; last_of_run marks the final byte of an input beat and
//   range_error is set on every byte of a beat whose escape delta was cut
// each input beat gives six to ten bytes; the one-byte output register sets
//   the rate, and an item's bytes are its code bits plus pending bits, over
//   eight, plus a flush byte for leftover bits at end_of_stream
// the first byte of a beat travels from the input register through the code
//   register and the byte buffer to the output register
// the next item's code word is built while the current one drains, so bytes
//   leave back to back across item boundaries
// reset clears the previous endpoint, the pending bits and all valid flags;
//   no clearing pass is needed
// when the receiver stalls the output byte holds, the byte buffer stops and
//   in_stall rises once the two pipeline registers are full
module delta_prefix_bit_packer_core
  import dpbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] endpoint,
  input  logic [33:0] chain_index,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        range_error
);

  // code word handed from the encoder to the byte packer
  logic  code_valid;
  logic  code_take;
  code_t code;

  // delta, prefix lookup and code word assembly
  dpbp_encode u_encode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .endpoint      (endpoint),
    .chain_index   (chain_index),
    .end_of_stream (end_of_stream),
    .code_valid    (code_valid),
    .code          (code),
    .code_take     (code_take)
  );

  // merge with pending bits, then shift out one byte per beat
  dpbp_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .code_valid  (code_valid),
    .code        (code),
    .code_take   (code_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .range_error (range_error)
  );

endmodule

FILE: design/dpbp_checker.sv
module dpbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       range_error
);

  // nothing in flight straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

  // a held byte stays valid
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped under stall");

  // a held byte keeps its value
  a_byte_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_byte) && $stable(last_of_run))
    else $error("output payload changed under stall");

  // the error flag is the same on every byte of one run
  a_err_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> !out_valid ||
      range_error == $past(range_error))
    else $error("range_error changed within a run");

endmodule

bind delta_prefix_bit_packer_core dpbp_checker u_dpbp_checker (.*);
